>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the list engine top; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Invariant checked at every clock edge outside reset
`define PLE_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// Consequence that must hold in the cycle after the antecedent
`define PLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define PLE_ASSERT(label, expr)
`define PLE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Widths, request and status codes, and cell control types of the list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 16;
  localparam int MODE_W       = 4;
  localparam int STATUS_W     = 2;
  localparam int LEN_W        = 5;
  localparam int CAPACITY_DEF = 16;

  // Request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_HEAD = 4'd0,
    MODE_INS_TAIL = 4'd1,
    MODE_INS_AT   = 4'd2,
    MODE_RM_HEAD  = 4'd3,
    MODE_RM_TAIL  = 4'd4,
    MODE_RM_AT    = 4'd5,
    MODE_READ     = 4'd6,
    MODE_REPLACE  = 4'd7,
    MODE_SEARCH   = 4'd8,
    MODE_TEST_AT  = 4'd9,
    MODE_SWAP     = 4'd10,
    MODE_CLEAR    = 4'd11
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // What each cell does with its element this cycle
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,  // above p take left neighbor, at p take value
    CELL_REMOVE = 3'd2,  // at and above p take right neighbor
    CELL_LOAD   = 3'd3,  // at p take value
    CELL_SWAP   = 3'd4   // at p take second read, at p2 take first read
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

>>> src/ple_req_if.sv
// ----------------------------------------------------------------------------
// ple_req_if
// Request channel of the list engine: valid/ready plus one request item.
// ----------------------------------------------------------------------------
interface ple_req_if
  import ple_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;
  logic signed [POS_W-1:0]  position;
  logic signed [POS_W-1:0]  other_position;

  modport source (
    output valid, mode, value, position, other_position,
    input  ready
  );

  modport sink (
    input  valid, mode, value, position, other_position,
    output ready
  );
endinterface

>>> src/ple_rsp_if.sv
// ----------------------------------------------------------------------------
// ple_rsp_if
// Result channel of the list engine: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface ple_rsp_if
  import ple_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic                     hit;
  logic [STATUS_W-1:0]      status;
  logic [LEN_W-1:0]         length;

  modport source (
    output valid, read_value, hit, status, length,
    input  ready
  );

  modport sink (
    input  valid, read_value, hit, status, length,
    output ready
  );
endinterface

>>> src/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an element, shifts to/from its neighbors, and adds its
// contribution to the read and search chains that run through the row.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX      = 0,
  localparam int IW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [IW-1:0]     p,
  input  logic [IW-1:0]     p2,
  input  logic [CW-1:0]     count,
  input  logic [DATA_W-1:0] swap_a,
  input  logic [DATA_W-1:0] swap_b,
  input  logic [DATA_W-1:0] left_elem,
  input  logic [DATA_W-1:0] right_elem,
  input  logic [DATA_W-1:0] rd_a_in,
  input  logic [DATA_W-1:0] rd_b_in,
  input  logic              hit_in,
  output logic [DATA_W-1:0] elem,
  output logic [DATA_W-1:0] rd_a_out,
  output logic [DATA_W-1:0] rd_b_out,
  output logic              hit_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  logic [DATA_W-1:0] elem_next;
  logic              at_p;
  logic              at_p2;
  logic              above_p;
  logic              in_list;

  assign at_p    = (p == MY_IDX);
  assign at_p2   = (p2 == MY_IDX);
  assign above_p = (MY_IDX > p);
  assign in_list = (MY_CNT < count);

  // Read and search chains: each cell ORs in its own term
  assign rd_a_out = rd_a_in | (at_p  ? elem : '0);
  assign rd_b_out = rd_b_in | (at_p2 ? elem : '0);
  assign hit_out  = hit_in  | (in_list && (elem == ctl.value));

  // Element update
  always_comb begin
    elem_next = elem;
    unique case (ctl.op)
      CELL_INSERT: begin
        if (at_p) elem_next = ctl.value;
        else if (above_p) elem_next = left_elem;
      end
      CELL_REMOVE: begin
        if (at_p || above_p) elem_next = right_elem;
      end
      CELL_LOAD: begin
        if (at_p) elem_next = ctl.value;
      end
      CELL_SWAP: begin
        if (at_p) elem_next = swap_b;
        else if (at_p2) elem_next = swap_a;
      end
      default: elem_next = elem;
    endcase
  end

  always_ff @(posedge clk) begin
    elem <= elem_next;
  end

endmodule

>>> src/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// The engine takes one request item per clock cycle while it is ready and returns one
// result item per request, registered, in the cycle after acceptance; the request side
// stays ready while the result register is empty or being drained. Every
// operation (insert, remove, read, replace, search, test, swap, clear)
// finishes in the cycle in which it is accepted: each cell shifts to or from its neighbor,
// compares against the request value, and ORs its term into read and search
// chains that run through the whole row, so the length of those chains
// (CAPACITY cells) sets the cycle time. No clearing pass is needed after
// reset; only the element count is reset.
module positional_list_engine_top
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     count_inc;
  logic [CW-1:0]     count_dec;
  logic [POS_W-1:0]  count_pos;
  logic              acc;
  logic              pos_ok;
  logic              ins_ok;
  logic              pos2_ok;
  logic              full;
  cell_ctl_t         ctl;
  logic [IW-1:0]     p;
  logic [IW-1:0]     p2;
  logic [DATA_W-1:0] rd;
  logic              hit;
  status_t           st;
  logic [CW+LEN_W-1:0] len_ext;
  logic [CW+LEN_W-1:0] count_ext;
  logic                ins_refused;

  logic [DATA_W-1:0] elem   [CAPACITY];
  logic [DATA_W-1:0] rd_a_c [CAPACITY+1];
  logic [DATA_W-1:0] rd_b_c [CAPACITY+1];
  logic              hit_c  [CAPACITY+1];

  // Handshake: accept while the result register is free or being taken
  assign req.ready = !rsp.valid || rsp.ready;
  assign acc       = req.valid && req.ready;

  // Index checks against the current count
  assign count_pos = POS_W'(count);
  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);
  assign full      = (count == CAP_CNT);
  assign pos_ok    = !req.position[POS_W-1] && ($unsigned(req.position) < count_pos);
  assign ins_ok    = !req.position[POS_W-1] && ($unsigned(req.position) <= count_pos);
  assign pos2_ok   = !req.other_position[POS_W-1] &&
                     ($unsigned(req.other_position) < count_pos);

  // Request decode
  always_comb begin
    ctl.op     = CELL_HOLD;
    ctl.value  = req.value;
    p          = req.position[IW-1:0];
    p2         = req.other_position[IW-1:0];
    rd         = '0;
    hit        = 1'b0;
    st         = ST_OK;
    count_next = count;
    unique case (mode_t'(req.mode))
      MODE_INS_HEAD: begin
        p = '0;
        if (full) st = ST_FULL;
        else begin
          ctl.op     = CELL_INSERT;
          count_next = count_inc;
        end
      end
      MODE_INS_TAIL: begin
        p = count[IW-1:0];
        if (full) st = ST_FULL;
        else begin
          ctl.op     = CELL_INSERT;
          count_next = count_inc;
        end
      end
      MODE_INS_AT: begin
        if (!ins_ok) st = ST_RANGE;
        else if (full) st = ST_FULL;
        else begin
          ctl.op     = CELL_INSERT;
          count_next = count_inc;
        end
      end
      MODE_RM_HEAD: begin
        p = '0;
        if (count == '0) st = ST_EMPTY;
        else begin
          ctl.op     = CELL_REMOVE;
          count_next = count_dec;
        end
      end
      MODE_RM_TAIL: begin
        p = count_dec[IW-1:0];
        if (count == '0) st = ST_EMPTY;
        else begin
          ctl.op     = CELL_REMOVE;
          count_next = count_dec;
        end
      end
      MODE_RM_AT: begin
        if (!pos_ok) st = ST_RANGE;
        else begin
          ctl.op     = CELL_REMOVE;
          count_next = count_dec;
        end
      end
      MODE_READ: begin
        if (!pos_ok) begin
          st = ST_RANGE;
          rd = '1;
        end else rd = rd_a_c[CAPACITY];
      end
      MODE_REPLACE: begin
        if (!pos_ok) st = ST_RANGE;
        else ctl.op = CELL_LOAD;
      end
      MODE_SEARCH: begin
        hit = hit_c[CAPACITY];
      end
      MODE_TEST_AT: begin
        if (!pos_ok) st = ST_RANGE;
        else hit = (rd_a_c[CAPACITY] == req.value);
      end
      MODE_SWAP: begin
        if (!(pos_ok && pos2_ok)) st = ST_RANGE;
        else ctl.op = CELL_SWAP;
      end
      MODE_CLEAR: begin
        count_next = '0;
      end
      default: st = ST_OK;
    endcase
    // cells only move on an accepted item
    if (!acc) ctl.op = CELL_HOLD;
  end

  // Row of cells
  assign rd_a_c[0] = '0;
  assign rd_b_c[0] = '0;
  assign hit_c[0]  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_elem;
    logic [DATA_W-1:0] right_elem;

    if (i == 0) begin : g_first
      assign left_elem = '0;
    end else begin : g_mid
      assign left_elem = elem[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_elem = '0;
    end else begin : g_inner
      assign right_elem = elem[i+1];
    end

    ple_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .p          (p),
      .p2         (p2),
      .count      (count),
      .swap_a     (rd_a_c[CAPACITY]),
      .swap_b     (rd_b_c[CAPACITY]),
      .left_elem  (left_elem),
      .right_elem (right_elem),
      .rd_a_in    (rd_a_c[i]),
      .rd_b_in    (rd_b_c[i]),
      .hit_in     (hit_c[i]),
      .elem       (elem[i]),
      .rd_a_out   (rd_a_c[i+1]),
      .rd_b_out   (rd_b_c[i+1]),
      .hit_out    (hit_c[i+1])
    );
  end

  // Element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (acc) begin
      count <= count_next;
    end
  end

  // Result register
  assign len_ext = (CW + LEN_W)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (acc) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.read_value <= rd;
      rsp.hit        <= hit;
      rsp.status     <= st;
      rsp.length     <= len_ext[LEN_W-1:0];
    end
  end

  // Checks
  assign count_ext   = (CW + LEN_W)'(count);
  assign ins_refused = acc && (req.mode == MODE_INS_HEAD) && full;

  `include "assert_macros.svh"

  `PLE_ASSERT(a_count_bound, count <= CAP_CNT)
  `PLE_ASSERT(a_len_tracks_count, !rsp.valid || acc || rsp.length == count_ext[LEN_W-1:0])
  `PLE_ASSERT_NEXT(a_full_refused, ins_refused, rsp.valid && rsp.status == ST_FULL && full)
  `PLE_ASSERT_NEXT(a_clear_empties, acc && req.mode == MODE_CLEAR, count == '0 && rsp.length == '0)

endmodule

>>> test/tb_positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// tb_positional_list_engine_top
// Self-checking bench for the positional list engine. The bench keeps its own
// copy of the list and predicts every result item. Requests come from a queue
// that a directed part and a random part fill. Both sides idle and stall at
// random over four phases, and the bench drains fully between phases.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_top;
  import ple_pkg::*;

  localparam int CAP            = CAPACITY_DEF;
  localparam int RANDOM_PER_PH  = 332;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic signed [POS_W-1:0]  position;
    logic signed [POS_W-1:0]  other_position;
  } list_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     hit;
    status_t                  status;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  logic clk;
  logic rst;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Bench copy of the list
  logic signed [DATA_W-1:0] list_values [CAP];
  int                       list_len;

  list_req_t    pending_requests [$];
  list_result_t expected_results [$];
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           quiet_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // List prediction
  // --------------------------------------------------------------------------
  function automatic bit in_list(int idx);
    return idx >= 0 && idx < list_len;
  endfunction

  // Range check comes before the full check
  function automatic status_t list_insert(logic signed [DATA_W-1:0] v, int idx);
    if (idx < 0 || idx > list_len) return ST_RANGE;
    if (list_len >= CAP) return ST_FULL;
    for (int i = list_len; i > idx; i--) list_values[i] = list_values[i-1];
    list_values[idx] = v;
    list_len++;
    return ST_OK;
  endfunction

  function automatic void list_remove(int idx);
    for (int i = idx; i + 1 < list_len; i++) list_values[i] = list_values[i+1];
    list_len--;
  endfunction

  function automatic list_result_t apply_request(list_req_t r);
    list_result_t             res;
    int                       p;
    int                       q;
    logic signed [DATA_W-1:0] held;
    p              = r.position;
    q              = r.other_position;
    res.read_value = '0;
    res.hit        = 1'b0;
    res.status     = ST_OK;
    case (r.mode)
      MODE_INS_HEAD: res.status = list_insert(r.value, 0);
      MODE_INS_TAIL: res.status = list_insert(r.value, list_len);
      MODE_INS_AT:   res.status = list_insert(r.value, p);
      MODE_RM_HEAD, MODE_RM_TAIL: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else list_remove((r.mode == MODE_RM_HEAD) ? 0 : list_len - 1);
      end
      MODE_RM_AT: begin
        if (!in_list(p)) res.status = ST_RANGE;
        else list_remove(p);
      end
      MODE_READ: begin
        if (!in_list(p)) begin
          res.status     = ST_RANGE;
          res.read_value = -1;
        end else begin
          res.read_value = list_values[p];
        end
      end
      MODE_REPLACE: begin
        if (!in_list(p)) res.status = ST_RANGE;
        else list_values[p] = r.value;
      end
      MODE_SEARCH: begin
        for (int i = 0; i < list_len; i++)
          if (list_values[i] == r.value) res.hit = 1'b1;
      end
      MODE_TEST_AT: begin
        if (!in_list(p)) res.status = ST_RANGE;
        else res.hit = (list_values[p] == r.value);
      end
      MODE_SWAP: begin
        if (!in_list(p) || !in_list(q)) begin
          res.status = ST_RANGE;
        end else begin
          held           = list_values[p];
          list_values[p] = list_values[q];
          list_values[q] = held;
        end
      end
      MODE_CLEAR: list_len = 0;
      default: ;
    endcase
    res.length = LEN_W'(list_len);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_request(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value,
                               logic signed [POS_W-1:0] position,
                               logic signed [POS_W-1:0] other_position);
    list_req_t r;
    r.mode           = mode;
    r.value          = value;
    r.position       = position;
    r.other_position = other_position;
    pending_requests.push_back(r);
  endtask

  // Mostly indices near the list, some -1, some anywhere in 16 bits
  function automatic logic signed [POS_W-1:0] random_index();
    int u;
    u = $urandom_range(99);
    if (u < 85) return POS_W'($urandom_range(CAP));
    if (u < 90) return '1;
    return POS_W'($urandom());
  endfunction

  // Inserts slightly outweigh removes so the list often fills up
  function automatic list_req_t random_request();
    list_req_t r;
    int        sel;
    sel = $urandom_range(999);
    if (sel < 110)      r.mode = MODE_INS_HEAD;
    else if (sel < 220) r.mode = MODE_INS_TAIL;
    else if (sel < 320) r.mode = MODE_INS_AT;
    else if (sel < 400) r.mode = MODE_RM_HEAD;
    else if (sel < 480) r.mode = MODE_RM_TAIL;
    else if (sel < 570) r.mode = MODE_RM_AT;
    else if (sel < 660) r.mode = MODE_READ;
    else if (sel < 730) r.mode = MODE_REPLACE;
    else if (sel < 810) r.mode = MODE_SEARCH;
    else if (sel < 890) r.mode = MODE_TEST_AT;
    else if (sel < 975) r.mode = MODE_SWAP;
    else if (sel < 988) r.mode = MODE_CLEAR;
    else                r.mode = MODE_W'($urandom_range(15, 12));
    // small value pool so searches and tests hit often
    if ($urandom_range(2) != 0) r.value = DATA_W'(int'($urandom_range(5)) - 2);
    else r.value = $urandom();
    r.position       = random_index();
    r.other_position = random_index();
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    if (mismatch_count < 10) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_req_t r;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r                     = pending_requests.pop_front();
        req_ch.valid          <= 1'b1;
        req_ch.mode           <= r.mode;
        req_ch.value          <= r.value;
        req_ch.position       <= r.position;
        req_ch.other_position <= r.other_position;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: check results first, then predict newly accepted requests
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_result_t want;
    list_req_t    got_req;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          log_mismatch("result item with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.read_value !== want.read_value || rsp_ch.hit !== want.hit ||
              rsp_ch.status !== want.status || rsp_ch.length !== want.length)
            log_mismatch($sformatf(
              "read_value %0d hit %0b status %0d length %0d, expected %0d %0b %0d %0d",
              rsp_ch.read_value, rsp_ch.hit, rsp_ch.status, rsp_ch.length,
              want.read_value, want.hit, want.status, want.length));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        got_req.mode           = req_ch.mode;
        got_req.value          = req_ch.value;
        got_req.position       = req_ch.position;
        got_req.other_position = req_ch.other_position;
        expected_results.push_back(apply_request(got_req));
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("positional_list_engine_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, four phases, drain, verdict
  // --------------------------------------------------------------------------
  initial begin
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.mode           = '0;
    req_ch.value          = '0;
    req_ch.position       = '0;
    req_ch.other_position = '0;
    rsp_ch.ready          = 1'b0;
    list_len              = 0;
    mismatch_count        = 0;
    quiet_cycles          = 0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase

      if (ph == 0) begin
        // empty list: reads, removes, search and swap all fail or miss
        queue_request(MODE_READ,    0, 0, 0);
        queue_request(MODE_RM_HEAD, 0, 0, 0);
        queue_request(MODE_RM_TAIL, 0, 0, 0);
        queue_request(MODE_RM_AT,   0, 0, 0);
        queue_request(MODE_SEARCH,  0, 0, 0);
        queue_request(MODE_SWAP,    0, 0, 0);
        queue_request(MODE_INS_AT,  5, 1, 0);
        // fill to capacity with every insert flavor and extreme values
        for (int i = 0; i < CAP; i++)
          queue_request(MODE_W'(i % 3),
                        (i % 2) ? 32'sh7fff_ffff - i : 32'sh8000_0000 + i,
                        POS_W'(i / 2), 0);
        queue_request(MODE_INS_HEAD, 7, 0, 0);
        queue_request(MODE_INS_AT,   7, 17, 0);
        queue_request(MODE_REPLACE,  9, 16, 0);
        queue_request(MODE_SWAP,     0, 0, 15);
        queue_request(MODE_TEST_AT,  32'sh8000_0001, 0, 0);
        queue_request(MODE_CLEAR,    0, 0, 0);
      end
      for (int n = 0; n < RANDOM_PER_PH; n++) pending_requests.push_back(random_request());

      // hold off new requests until every result of this phase is back
      while (pending_requests.size() != 0 || req_ch.valid) @(negedge clk);
      while (expected_results.size() != 0) @(negedge clk);
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("positional_list_engine_top test passed");
    end else begin
      $display("positional_list_engine_top test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/ple_pkg.sv
src/ple_req_if.sv
src/ple_rsp_if.sv
src/ple_cell.sv
src/positional_list_engine_top.sv
test/tb_positional_list_engine_top.sv
